>>> rtl/kps_pkg.sv
// Package with the shared constants, types and address helper of the keyframe path sequencer.
`timescale 1ns / 1ps
package kps_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int WP_FIELDS     = 10;
    localparam int STORE_DEPTH   = MAX_WAYPOINTS * WP_FIELDS;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam logic [16:0] Q_ONE     = 17'd65536;
    localparam logic [16:0] Q_HALF    = 17'd32768;
    localparam logic [17:0] Q_TWO     = 18'd131072;
    localparam logic [30:0] DUR_FLOOR = 31'd66;

    localparam logic [3:0] FLD_DURATION = 4'd7;
    localparam logic [3:0] FLD_HOLD     = 4'd8;
    localparam logic [3:0] FLD_EASING   = 4'd9;

    localparam logic [31:0] EASE_IN     = 32'd1;
    localparam logic [31:0] EASE_OUT    = 32'd2;
    localparam logic [31:0] EASE_IN_OUT = 32'd3;
    localparam logic [31:0] EASE_SMASH  = 32'd4;

    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_LOOP    = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_PLAY  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    function automatic logic [ADDR_W-1:0] wp_addr(input logic [4:0] wp, input logic [3:0] f);
        logic [8:0] s;
        s = 9'({wp, 3'b000}) + 9'({wp, 1'b0}) + 9'(f);
        return ADDR_W'(s);
    endfunction

endpackage

>>> rtl/kps_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module kps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/keyframe_path_sequencer.sv
// Top level of the keyframe path sequencer: command handling, serial divider and shared multiplier.
//
// Channel  Direction  Handshake          Content
// s_       in         s_tvalid/s_tready  command: tuser op, tdata waypoint write or tick time
// m_       out        m_tvalid/m_tready  one result per command: tuser pose valid, tdata pose
// cfg_     in         cfg_we             enable, loop enable and waypoint count
//
// A field write, play, stop or a tick that yields no pose is answered straight from the idle state.
// A tick in a hold phase reads the held pose from the table; an advancing tick runs the 47-step
// restoring divider, then S_LA, S_LB, S_LC, S_LMUL and S_LACC per pose axis on the shared multiplier.
// Reset is synchronous and active low; the waypoint table is not cleared.
// A stalled result is held in the output register and blocks only the next command.
`timescale 1ns / 1ps
module keyframe_path_sequencer
    import kps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // wp_index, field_sel, field_value, delta_t, zero pad
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [231:0] m_tdata,   // pos_x..z, look_x..z, fov_out, playing_flag,
                                    // complete_flag, segment_out, zero pad
    output logic         m_tuser,   // pose_valid
    input  logic         cfg_we,
    input  logic [1:0]   cfg_idx,
    input  logic [4:0]   cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_HRD, S_HCAP, S_DRD, S_DCAP, S_DIV, S_PROG, S_HOLDCAP, S_CODECAP,
        S_EMUL, S_EASE, S_LA, S_LB, S_LC, S_LMUL, S_LACC, S_DONE
    } state_t;

    state_t state_reg;

    logic        enabled_reg, loop_reg;
    logic [4:0]  count_reg;
    logic [4:0]  segment_reg, from_reg;
    logic signed [31:0] progress_reg;
    logic        playing_reg, complete_reg;

    logic [30:0] dt_reg;
    logic [30:0] divisor_reg;
    logic [31:0] rem_reg;
    logic [46:0] quo_reg;
    logic [5:0]  div_cnt_reg;
    logic [16:0] t_reg;
    logic        adv_reg;
    logic [31:0] psat_reg;
    logic [31:0] code_reg;
    logic [16:0] e_reg;
    logic [31:0] a_reg;
    logic [2:0]  k_reg;
    logic [31:0] pose_reg [7];

    logic signed [33:0] mul_a_reg;
    logic signed [18:0] mul_b_reg;
    logic signed [52:0] prod_reg;

    logic         m_tvalid_reg;
    logic [231:0] m_tdata_reg;
    logic         m_tuser_reg;

    logic        out_free, accept;
    op_t         op;
    logic [3:0]  in_wp, in_fs;
    logic [31:0] in_val;
    logic [30:0] in_dt;
    logic [4:0]  cnt;
    logic [4:0]  to_seg;

    logic        playing_next, complete_next;
    logic [4:0]  segment_next;
    logic signed [31:0] progress_next;
    logic        go_hold, go_main;
    logic [32:0] hold_sum;

    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_data;
    logic              ram_we;

    logic [31:0] trial;
    logic        trial_ge;
    logic [30:0] qsat;
    logic [32:0] psum;
    logic [31:0] psat;
    logic [17:0] sq_op;
    logic [16:0] ease_val;
    logic [32:0] diff;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign in_wp    = s_tdata[3:0];
    assign in_fs    = s_tdata[7:4];
    assign in_val   = s_tdata[39:8];
    assign in_dt    = s_tdata[70:40];
    assign cnt      = (count_reg > 5'(MAX_WAYPOINTS)) ? 5'(MAX_WAYPOINTS) : count_reg;
    assign to_seg   = from_reg + 5'd1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign ram_we = accept && (op == OP_WRITE) && (in_fs < 4'(WP_FIELDS));

    kps_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_addr({1'b0, in_wp}, in_fs)),
        .wdata (in_val),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        rd_addr = '0;
        unique case (state_reg)
            S_HRD:     rd_addr = wp_addr(from_reg, {1'b0, k_reg});
            S_LA:      rd_addr = wp_addr(from_reg, {1'b0, k_reg});
            S_LB:      rd_addr = wp_addr(to_seg, {1'b0, k_reg});
            S_DRD:     rd_addr = wp_addr(to_seg, FLD_DURATION);
            S_PROG:    rd_addr = wp_addr(to_seg, FLD_HOLD);
            S_HOLDCAP: rd_addr = wp_addr(to_seg, FLD_EASING);
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        playing_next  = playing_reg;
        complete_next = complete_reg;
        segment_next  = segment_reg;
        progress_next = progress_reg;
        go_hold       = 1'b0;
        go_main       = 1'b0;
        hold_sum      = {progress_reg[31], progress_reg} + {2'b00, in_dt};
        unique case (op)
            OP_WRITE: ;
            OP_TICK: begin
                if (enabled_reg && playing_reg && cnt >= 5'd2) begin
                    if (segment_reg >= cnt - 5'd1) begin
                        if (loop_reg) begin
                            segment_next  = '0;
                            progress_next = '0;
                        end else begin
                            playing_next  = 1'b0;
                            complete_next = 1'b1;
                        end
                    end else if (progress_reg[31]) begin
                        progress_next = hold_sum[32] ? hold_sum[31:0] : '0;
                        go_hold       = 1'b1;
                    end else begin
                        go_main = 1'b1;
                    end
                end
            end
            OP_PLAY: begin
                if (cnt >= 5'd2) begin
                    playing_next  = 1'b1;
                    complete_next = 1'b0;
                    segment_next  = '0;
                    progress_next = '0;
                end
            end
            OP_STOP: begin
                playing_next  = 1'b0;
                segment_next  = '0;
                progress_next = '0;
            end
            default: ;
        endcase
    end

    assign trial    = {rem_reg[30:0], quo_reg[46]};
    assign trial_ge = trial >= {1'b0, divisor_reg};
    assign qsat     = (|quo_reg[46:31]) ? 31'h7FFFFFFF : quo_reg[30:0];
    assign psum     = {1'b0, progress_reg} + {2'b00, qsat};
    assign psat     = (psum[32] || psum[31]) ? 32'h7FFFFFFF : psum[31:0];
    assign diff     = {rd_data[31], rd_data} - {a_reg[31], a_reg};

    always_comb begin
        if (rd_data == EASE_IN) begin
            sq_op = {1'b0, t_reg};
        end else if (rd_data == EASE_OUT) begin
            sq_op = 18'(Q_ONE - t_reg);
        end else if (rd_data == EASE_IN_OUT) begin
            sq_op = (t_reg < Q_HALF) ? {1'b0, t_reg} : (Q_TWO - {t_reg, 1'b0});
        end else begin
            sq_op = '0;
        end
    end

    always_comb begin
        if (code_reg == EASE_IN) begin
            ease_val = prod_reg[32:16];
        end else if (code_reg == EASE_OUT) begin
            ease_val = Q_ONE - prod_reg[32:16];
        end else if (code_reg == EASE_IN_OUT) begin
            ease_val = (t_reg < Q_HALF) ? prod_reg[31:15] : (Q_ONE - prod_reg[33:17]);
        end else if (code_reg == EASE_SMASH) begin
            ease_val = t_reg[16] ? Q_ONE : 17'd0;
        end else begin
            ease_val = t_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            enabled_reg  <= 1'b1;
            loop_reg     <= 1'b0;
            count_reg    <= '0;
            segment_reg  <= '0;
            progress_reg <= '0;
            playing_reg  <= 1'b0;
            complete_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_ENABLED: enabled_reg <= cfg_wdata[0];
                    CFG_LOOP:    loop_reg    <= cfg_wdata[0];
                    CFG_COUNT:   count_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        playing_reg  <= playing_next;
                        complete_reg <= complete_next;
                        segment_reg  <= segment_next;
                        progress_reg <= progress_next;
                        from_reg     <= segment_reg;
                        dt_reg       <= in_dt;
                        k_reg        <= '0;
                        if (go_hold) begin
                            state_reg <= S_HRD;
                        end else if (go_main) begin
                            state_reg <= S_DRD;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                            m_tuser_reg  <= 1'b0;
                            m_tdata_reg  <= {1'b0, segment_next, complete_next,
                                             playing_next, 224'd0};
                        end
                    end
                end
                S_HRD: state_reg <= S_HCAP;
                S_HCAP: begin
                    pose_reg[k_reg] <= rd_data;
                    k_reg           <= k_reg + 3'd1;
                    state_reg       <= (k_reg == 3'd6) ? S_DONE : S_HRD;
                end
                S_DRD: state_reg <= S_DCAP;
                S_DCAP: begin
                    divisor_reg <= (rd_data[31] || rd_data == '0) ? DUR_FLOOR : rd_data[30:0];
                    quo_reg     <= {dt_reg, 16'd0};
                    rem_reg     <= '0;
                    div_cnt_reg <= 6'd46;
                    state_reg   <= S_DIV;
                end
                S_DIV: begin
                    rem_reg     <= trial_ge ? (trial - {1'b0, divisor_reg}) : trial;
                    quo_reg     <= {quo_reg[45:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == '0) begin
                        state_reg <= S_PROG;
                    end
                end
                S_PROG: begin
                    psat_reg  <= psat;
                    adv_reg   <= psat >= {15'd0, Q_ONE};
                    t_reg     <= (psat >= {15'd0, Q_ONE}) ? Q_ONE : psat[16:0];
                    state_reg <= S_HOLDCAP;
                end
                S_HOLDCAP: begin
                    if (adv_reg) begin
                        segment_reg  <= to_seg;
                        progress_reg <= (!rd_data[31] && rd_data != '0) ? -rd_data : '0;
                    end else begin
                        progress_reg <= psat_reg;
                    end
                    state_reg <= S_CODECAP;
                end
                S_CODECAP: begin
                    code_reg  <= rd_data;
                    mul_a_reg <= $signed({16'd0, sq_op});
                    mul_b_reg <= $signed({1'b0, sq_op});
                    state_reg <= S_EMUL;
                end
                S_EMUL: state_reg <= S_EASE;
                S_EASE: begin
                    e_reg     <= ease_val;
                    state_reg <= S_LA;
                end
                S_LA: state_reg <= S_LB;
                S_LB: begin
                    a_reg     <= rd_data;
                    state_reg <= S_LC;
                end
                S_LC: begin
                    mul_a_reg <= $signed({diff[32], diff});
                    mul_b_reg <= $signed({2'b00, e_reg});
                    state_reg <= S_LMUL;
                end
                S_LMUL: state_reg <= S_LACC;
                S_LACC: begin
                    pose_reg[k_reg] <= a_reg + prod_reg[47:16];
                    k_reg           <= k_reg + 3'd1;
                    state_reg       <= (k_reg == 3'd6) ? S_DONE : S_LA;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= 1'b1;
                        m_tdata_reg  <= {1'b0, segment_reg, complete_reg, playing_reg,
                                         pose_reg[6], pose_reg[5], pose_reg[4], pose_reg[3],
                                         pose_reg[2], pose_reg[1], pose_reg[0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(playing_reg && complete_reg))
        else $error("Playing and complete are set together.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        segment_reg <= 5'(MAX_WAYPOINTS))
        else $error("Segment index is beyond the table.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRD) |-> !progress_reg[31])
        else $error("Advancing tick started during a hold phase.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LA) |-> (e_reg <= Q_ONE))
        else $error("Eased fraction exceeds one.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_tvalid && m_tuser && state_reg == S_IDLE))
        else $error("Pose transfer was not presented.");
`endif

endmodule
